/* src/sfe_pkg.sv */
package sfe_pkg;

  // Number of channels carried in one frame (1 to 16).
  localparam int CHANNELS = 16;

  localparam int COUNT_W = 11;
  localparam int PULSE_W = 16;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam int DATA_BYTES = 22;

  // Scaling: count = floor((16 * (pulse - 874) + 5) / 10), saturated to 2047.
  localparam logic [PULSE_W-1:0] PULSE_OFFSET = 16'd874;
  // From this difference on the count would exceed 2047.
  localparam logic [PULSE_W-1:0] SAT_DIFF = 16'd1280;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;
  // Division by ten as a multiply by ceil(2^19 / 10), exact for the range used.
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               last;
  } chan_item_t;

endpackage

/* src/sfe_front.sv */
module sfe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       pulse_value,
  input  logic              last_supplied,
  output logic              push,
  output sfe_pkg::chan_item_t push_item,
  input  logic              fifo_full
);
  import sfe_pkg::*;

  logic [PULSE_W-1:0] diff;
  logic               below;
  logic               sat;
  logic [14:0]        scaled;
  logic [30:0]        product;
  logic [COUNT_W-1:0] count;
  logic               held_valid;
  chan_item_t         held_item;

  // Scale one pulse width to an SBUS count.
  always_comb begin
    below   = pulse_value < PULSE_OFFSET;
    diff    = pulse_value - PULSE_OFFSET;
    sat     = diff >= SAT_DIFF;
    scaled  = {diff[10:0], 4'b0000} + 15'd5;
    product = 31'(scaled) * 31'(RECIP_TEN);
    if (below) begin
      count = '0;
    end else if (sat) begin
      count = COUNT_MAX;
    end else begin
      count = product[RECIP_SHIFT +: COUNT_W];
    end
  end

  assign push      = held_valid && !fifo_full;
  assign in_ready  = !held_valid || !fifo_full;
  assign push_item = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item.count <= count;
      held_item.last  <= last_supplied;
    end
  end

endmodule

/* src/sfe_fifo.sv */
module sfe_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfe_pkg::chan_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output sfe_pkg::chan_item_t head_item
);
  import sfe_pkg::*;

  localparam int DEPTH = 4;

  chan_item_t entries [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign full       = fill == 3'(DEPTH);
  assign head_valid = fill != 3'd0;
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        fill <= fill + 3'd1;
      end else if (pop && !push) begin
        fill <= fill - 3'd1;
      end
    end
  end

endmodule

/* src/sfe_back.sv */
module sfe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  sfe_pkg::chan_item_t head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import sfe_pkg::*;

  typedef enum logic [1:0] {
    S_DATA,
    S_BYTE2,
    S_PAD,
    S_END
  } state_t;

  state_t      state;
  logic [17:0] acc;
  logic [3:0]  held;
  logic [4:0]  chan;
  logic [4:0]  data_cnt;
  logic        start_sent;
  logic        frame_end;

  logic        can_emit;
  logic [17:0] keep_mask;
  logic [17:0] merged;
  logic [3:0]  held_after;
  logic [4:0]  chan_next;
  logic        end_next;

  always_comb begin
    can_emit   = !out_valid || out_ready;
    keep_mask  = (18'd1 << held[2:0]) - 18'd1;
    merged     = ({7'b0, head_item.count} << held[2:0]) | (acc & keep_mask);
    held_after = held + 4'd3;
    chan_next  = chan + 5'd1;
    end_next   = head_item.last || (chan_next >= 5'(CHANNELS));
    pop        = (state == S_DATA) && can_emit && head_valid && start_sent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_DATA;
      acc        <= '0;
      held       <= '0;
      chan       <= '0;
      data_cnt   <= '0;
      start_sent <= 1'b0;
      frame_end  <= 1'b0;
      out_valid  <= 1'b0;
      out_byte   <= '0;
      out_last   <= 1'b0;
    end else if (can_emit) begin
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      unique case (state)
        S_DATA: begin
          if (head_valid) begin
            out_valid <= 1'b1;
            if (!start_sent) begin
              out_byte   <= START_BYTE;
              start_sent <= 1'b1;
            end else begin
              out_byte  <= merged[7:0];
              acc       <= merged >> 8;
              held      <= held_after;
              chan      <= chan_next;
              data_cnt  <= data_cnt + 5'd1;
              frame_end <= end_next;
              if (held_after >= 4'd8) begin
                state <= S_BYTE2;
              end else if (end_next) begin
                state <= S_PAD;
              end
            end
          end
        end
        S_BYTE2: begin
          out_valid <= 1'b1;
          out_byte  <= acc[7:0];
          acc       <= acc >> 8;
          held      <= held - 4'd8;
          data_cnt  <= data_cnt + 5'd1;
          state     <= frame_end ? S_PAD : S_DATA;
        end
        S_PAD: begin
          out_valid <= 1'b1;
          if (data_cnt != 5'(DATA_BYTES)) begin
            // Leftover bits go out once, then zero bytes fill the frame.
            out_byte <= (held != 4'd0) ? acc[7:0] : 8'h00;
            acc      <= '0;
            held     <= '0;
            data_cnt <= data_cnt + 5'd1;
          end else begin
            out_byte <= 8'h00;
            state    <= S_END;
          end
        end
        S_END: begin
          out_valid  <= 1'b1;
          out_byte   <= 8'h00;
          out_last   <= 1'b1;
          acc        <= '0;
          held       <= '0;
          chan       <= '0;
          data_cnt   <= '0;
          start_sent <= 1'b0;
          frame_end  <= 1'b0;
          state      <= S_DATA;
        end
        default: begin
          state <= S_DATA;
        end
      endcase
    end
  end

endmodule

/* src/sbus_frame_encoder.sv */
// SBUS frame encoder. Each input beat carries one servo pulse width in microseconds
// (tdata, nominal 1000 to 2000) and is scaled to an 11-bit SBUS count as
// floor((16 * (pulse - 874) + 5) / 10), clamped to 0 below 874 and to 2047 above.
// Counts are packed LSB first into the 22 data bytes of a 25-byte frame that opens
// with the start byte 0x0F and closes with a flags byte and an end byte, both zero;
// only the end byte carries tlast. A frame closes after CHANNELS channels or on an
// input beat with tlast set, and the channels not supplied are sent as zero counts.
// The output carries one byte per beat. An input beat passes through a registered
// scaling stage into a four-entry queue; the packer behind it writes one byte per
// cycle into the output register unless the receiver stalls or the queue runs
// dry, so a channel yields one or two bytes (11 bits, about 1.4 bytes), the first
// channel of a frame one more for the start byte, and closing a frame emits the
// padding bytes, the flags byte and the end byte. Input beats are taken every cycle
// while the queue has room, so the sustained input rate is set by the byte rate at
// the output: a full frame of sixteen channels takes 25 bytes, shorter frames more.
module sbus_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] pulse_value
  input  logic        s_tlast,   // last_supplied
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] frame_byte
  output logic        m_tlast    // frame_last
);
  import sfe_pkg::*;

  logic       push;
  chan_item_t push_item;
  logic       fifo_full;
  logic       pop;
  logic       head_valid;
  chan_item_t head_item;

  // Scaling stage: turns each pulse width into a count.
  sfe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pulse_value  (s_tdata),
    .last_supplied(s_tlast),
    .push         (push),
    .push_item    (push_item),
    .fifo_full    (fifo_full)
  );

  // Short queue that lets the scaler and the packer stall independently.
  sfe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  // Bit packer and frame sequencer, one byte per cycle unless the output stalls or the queue is empty.
  sfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* src/sfe_checker.sv */
module sfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [15:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);
  import sfe_pkg::*;

  logic [4:0] beat_cnt;
  logic       in_seen;

  // Position of the next output beat within its frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= '0;
      in_seen  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_seen <= s_tlast || (s_tdata != 16'd0) || in_seen;
      end
      if (m_tvalid && m_tready) begin
        beat_cnt <= m_tlast ? 5'd0 : beat_cnt + 5'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && beat_cnt == 5'd0 |-> m_tdata == START_BYTE)
    else $error("frame does not open with the start byte");

  a_frame_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast == (beat_cnt == 5'd24))
    else $error("end byte not at the 25th position");

  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (beat_cnt == 5'd23 || beat_cnt == 5'd24) |-> m_tdata == 8'h00)
    else $error("flags or end byte not zero");

  a_in_seen_used: assert property (@(posedge clk) disable iff (rst)
    $rose(in_seen) |-> $past(s_tvalid && s_tready))
    else $error("input tracking changed without an input beat");

endmodule

bind sbus_frame_encoder sfe_checker u_sfe_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

/* test/tb.sv */
// Testbench for sbus_frame_encoder.
//
// Input beats carry one servo pulse width each. Output beats carry one byte each
// of a 25-byte frame. The bench keeps its own model of the encoder. For every
// input beat accepted, that model works out the frame bytes the beat completes
// and appends them to a queue. Every output beat is then checked field by field
// against the oldest byte in that queue.
//
// The stimulus runs as a series of named tests:
//   - scaling points around the offset and the saturation threshold, and the
//     field extremes;
//   - frames closed early by tlast, including a single-channel frame;
//   - a full frame of sixteen channels that closes with no tlast;
//   - a long receiver hold-off while the sender keeps offering beats;
//   - a sender pause until the output side has drained completely;
//   - random traffic, with the idle patterns switched from run to run.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfe_pkg::*;

  // The slowest legal run is about 400 single-channel frames of 25 bytes each,
  // with every byte stalled for the longest gap. That is well under CYCLE_LIMIT.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [15:0] pulse_value
  logic        s_tlast = 1'b0;  // last_supplied
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] frame_byte
  logic        m_tlast;         // frame_last

  sbus_frame_encoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The model's copy of the encoder state.
  logic [31:0] pack_bits;      // Packed channel bits not yet sent, LSB first.
  int unsigned pack_held;      // Number of valid bits in pack_bits.
  int unsigned chan_count;     // Channels taken into the current frame.
  bit          start_done;     // The start byte of the current frame has gone out.

  frame_beat_t expected_bytes[$];
  int          error_count = 0;
  int          cycle_count = 0;

  // Controls for the idle patterns. The tests write these and the drivers read them.
  bit tx_gaps_on = 1'b0;
  bit rx_gaps_on = 1'b0;
  int rx_hold_left = 0;   // Cycles of forced back-pressure still to apply.
  int rx_stall_left = 0;

  // Most gaps are short and a few are long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pulse width to an 11-bit count. Below the offset the count is zero, and
  // above 2047 it saturates. Note that (16*d + 5) / 10 rounds half up.
  function automatic logic [10:0] pulse_to_count(logic [15:0] pulse);
    int unsigned c;
    if (pulse < PULSE_OFFSET) return '0;
    c = (16 * (32'(pulse) - 32'(PULSE_OFFSET)) + 5) / 10;
    if (c > 32'(COUNT_MAX)) c = 32'(COUNT_MAX);
    return c[10:0];
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic l);
    expected_bytes.push_back('{frame_byte: b, frame_last: l});
  endfunction

  // Bytes caused by one accepted channel beat, in the order they must appear.
  function automatic void encode_pulse(logic [15:0] pulse, logic last_ch);
    int unsigned sent;
    if (!start_done) begin
      expect_byte(START_BYTE, 1'b0);
      start_done = 1'b1;
    end
    pack_bits = (pack_bits & ((32'd1 << pack_held) - 1))
              | (32'(pulse_to_count(pulse)) << pack_held);
    pack_held += COUNT_W;
    while (pack_held >= 8) begin
      expect_byte(pack_bits[7:0], 1'b0);
      pack_bits >>= 8;
      pack_held -= 8;
    end
    chan_count++;
    if (last_ch || chan_count >= CHANNELS) begin
      // The leftover bits go out in one byte, and zero bytes fill the frame up
      // to 22 data bytes. The flags byte and the end byte follow.
      sent = (chan_count * COUNT_W) / 8;
      if (sent > DATA_BYTES) sent = DATA_BYTES;
      while (sent < DATA_BYTES) begin
        expect_byte((pack_held != 0) ? pack_bits[7:0] : 8'h00, 1'b0);
        pack_bits = '0;
        pack_held = 0;
        sent++;
      end
      expect_byte(8'h00, 1'b0);
      expect_byte(8'h00, 1'b1);
      pack_bits = '0;
      pack_held = 0;
      chan_count = 0;
      start_done = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
    if (error_count < MAX_REPORTS)
      $display("[%0t] %s: expected 0x%02h, got 0x%02h", $realtime, what, want, got);
    error_count++;
  endfunction

  // One process samples both handshakes at the rising edge. Inputs change only
  // at the falling edge, so the sampled values are stable. An accepted input
  // beat is turned into expected bytes first. An accepted output beat is then
  // matched against the oldest expected byte.
  always @(posedge clk) begin : beat_monitor
    frame_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) encode_pulse(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch("output beat with no byte expected", 8'h00, m_tdata);
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.frame_byte)
            note_mismatch("frame_byte", want.frame_byte, m_tdata);
          if (m_tlast !== want.frame_last)
            note_mismatch("frame_last", 8'(want.frame_last), 8'(m_tlast));
        end
      end
    end
  end

  // Receiver. A forced hold-off takes priority. Otherwise, with gaps enabled,
  // tready drops now and then for a random stretch.
  always @(negedge clk) begin : rx_drive
    logic ready_next;
    if (rx_hold_left > 0) begin
      ready_next = 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      ready_next = 1'b0;
      rx_stall_left--;
    end else begin
      ready_next = 1'b1;
      if (rx_gaps_on && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
    end
    m_tready <= ready_next;
  end

  // Timeout. The run is a failure if it is still going at the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Offer one channel beat and return at the rising edge that accepts it.
  // tvalid stays high after acceptance, so the next call can follow without a
  // gap. A gap first lowers tvalid at a falling edge of its own.
  task automatic send_pulse(input logic [15:0] pulse, input logic last_ch);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pulse;
    s_tlast  <= last_ch;
    do @(posedge clk); while (!s_tready);
  endtask

  // Lower tvalid and wait until every expected byte has come out.
  task automatic drain_output();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_pulse();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1000, 2000));
    if (r < 85) return 16'($urandom_range(0, 2300));
    return 16'($urandom);
  endfunction

  // Values at the clamp points, on each side of both, at the nominal range,
  // and alternating bit patterns. The twelfth beat closes the frame early.
  task automatic test_scaling_points();
    logic [15:0] points [12];
    points = '{16'd0, 16'd873, 16'd874, 16'd875, 16'd1000, 16'd1500, 16'd2000,
               16'd2153, 16'd2154, 16'hFFFF, 16'h5555, 16'hAAAA};
    for (int i = 0; i < 12; i++) send_pulse(points[i], i == 11);
  endtask

  // Early end: a single-channel frame, then a three-channel frame.
  task automatic test_early_end();
    send_pulse(16'd2000, 1'b1);
    send_pulse(16'd1000, 1'b0);
    send_pulse(16'd1234, 1'b0);
    send_pulse(16'd1999, 1'b1);
  endtask

  // A full frame closes on its sixteenth channel with no tlast. The next frame
  // carries tlast on its sixteenth channel as well.
  task automatic test_full_frames();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    for (int i = 0; i < CHANNELS; i++) send_pulse(random_pulse(), 1'b0);
    for (int i = 0; i < CHANNELS; i++) send_pulse(random_pulse(), i == CHANNELS - 1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats back to back. The internal queue fills up and the input stalls.
  task automatic test_output_stall();
    tx_gaps_on = 1'b0;
    @(posedge clk);
    rx_hold_left = 300;
    for (int i = 0; i < 40; i++) send_pulse(random_pulse(), $urandom_range(0, 15) == 0);
  endtask

  // The sender stops in the middle of a frame until all output has drained,
  // and then finishes the frame.
  task automatic test_sender_pause();
    rx_gaps_on = 1'b1;
    for (int i = 0; i < 5; i++) send_pulse(random_pulse(), 1'b0);
    drain_output();
    for (int i = 0; i < 6; i++) send_pulse(random_pulse(), i == 5);
  endtask

  // Random traffic in runs of 50 beats. Each run draws a fresh idle pattern,
  // so some runs have no gaps on either side.
  task automatic test_random_traffic(input int beats);
    for (int i = 0; i < beats; i++) begin
      if (i % 50 == 0) begin
        tx_gaps_on = $urandom_range(0, 2) != 0;
        rx_gaps_on = $urandom_range(0, 2) != 0;
      end
      send_pulse(random_pulse(), $urandom_range(0, 11) == 0);
    end
  endtask

  initial begin
    pack_bits  = '0;
    pack_held  = 0;
    chan_count = 0;
    start_done = 1'b0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_scaling_points();
    test_early_end();
    test_full_frames();
    test_output_stall();
    test_sender_pause();
    test_random_traffic(290);

    // Let everything drain. Then wait a little longer, to catch any stray beat.
    drain_output();
    rx_gaps_on = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
